@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/rpdc_pkg.sv @@
// ---------------------------------------------------------------------------
// rpdc_pkg
// types and constants of the rolling plot draw command generator
// ---------------------------------------------------------------------------
`default_nettype none

package rpdc_pkg;

    localparam int XSCALE = 100;

    // floor(a/100) = (a * RECIP_GAIN) >> 32 for a < 2**26
    localparam logic [25:0] RECIP_GAIN = 26'd42949673;
    // floor(a/100) = (a * RECIP_X) >> 24 for a < 2**16
    localparam logic [17:0] RECIP_X = 18'd167773;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_RECT = 1'b1;

    typedef enum logic [2:0] {
        REG_PLOT_LEFT   = 3'd0,
        REG_PLOT_TOP    = 3'd1,
        REG_PLOT_WIDTH  = 3'd2,
        REG_PLOT_HEIGHT = 3'd3,
        REG_STEP        = 3'd4,
        REG_GAIN        = 3'd5,
        REG_BASELINE    = 3'd6,
        REG_COLORS      = 3'd7
    } cfg_addr_t;

    localparam logic [8:0]  RST_PLOT_LEFT   = 9'd0;
    localparam logic [8:0]  RST_PLOT_TOP    = 9'd0;
    localparam logic [8:0]  RST_PLOT_WIDTH  = 9'd320;
    localparam logic [8:0]  RST_PLOT_HEIGHT = 9'd240;
    localparam logic [11:0] RST_STEP        = 12'd100;
    localparam logic [9:0]  RST_GAIN        = 10'd100;
    localparam logic [9:0]  RST_BASELINE    = 10'd0;
    localparam logic [31:0] RST_COLORS      = 32'h0000_FFFF;

    typedef struct packed {
        logic        kind;
        logic [8:0]  x_start;
        logic [8:0]  y_start;
        logic [8:0]  x_end;
        logic [8:0]  y_end;
        logic [15:0] color;
        logic        last;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/rolling_plot_draw_commands.sv @@
// ---------------------------------------------------------------------------
// rolling_plot_draw_commands
// roll-mode plotter: samples in, line and fill-rectangle draw commands out
//
//   port group   direction   word
//   s_*          in          tuser = opcode, tdata = sample
//   m_*          out         tuser = kind, tlast = last, tdata = coords, color
//   p*           in/out      apb register file, 8 registers at 4*i
//
// a word is registered at s_, then passes three stages (gain multiply,
// reciprocal divide, row clamp) into a two-entry command buffer. a start
// yields one rectangle command, a sample a line and a rectangle or, on a
// wrap, the rectangle alone; the single m_ port sets the rate. reset is
// synchronous, and a stalled m_ side backs up stage by stage to s_tready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rolling_plot_draw_commands
    import rpdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample[15:0]
    input  wire logic        s_tuser,   // opcode[0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // x_start[8:0], y_start[17:9], x_end[26:18],
                                        // y_end[35:27], color[51:36], zero[55:52]
    output logic             m_tuser,   // kind[0]
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [8:0]  plot_left_reg, plot_top_reg, plot_width_reg, plot_height_reg;
    logic [11:0] step_reg;
    logic [9:0]  gain_reg;
    logic [9:0]  baseline_reg;
    logic [31:0] colors_reg;

    cfg_addr_t   cfg_addr;
    logic        cfg_wr;

    assign pready   = 1'b1;
    assign cfg_addr = cfg_addr_t'(paddr[4:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plot_left_reg   <= RST_PLOT_LEFT;
            plot_top_reg    <= RST_PLOT_TOP;
            plot_width_reg  <= RST_PLOT_WIDTH;
            plot_height_reg <= RST_PLOT_HEIGHT;
            step_reg        <= RST_STEP;
            gain_reg        <= RST_GAIN;
            baseline_reg    <= RST_BASELINE;
            colors_reg      <= RST_COLORS;
        end else if (cfg_wr) begin
            unique case (cfg_addr)
                REG_PLOT_LEFT:   plot_left_reg   <= pwdata[8:0];
                REG_PLOT_TOP:    plot_top_reg    <= pwdata[8:0];
                REG_PLOT_WIDTH:  plot_width_reg  <= pwdata[8:0];
                REG_PLOT_HEIGHT: plot_height_reg <= pwdata[8:0];
                REG_STEP:        step_reg        <= pwdata[11:0];
                REG_GAIN:        gain_reg        <= pwdata[9:0];
                REG_BASELINE:    baseline_reg    <= pwdata[9:0];
                REG_COLORS:      colors_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_addr)
            REG_PLOT_LEFT:   prdata = {23'd0, plot_left_reg};
            REG_PLOT_TOP:    prdata = {23'd0, plot_top_reg};
            REG_PLOT_WIDTH:  prdata = {23'd0, plot_width_reg};
            REG_PLOT_HEIGHT: prdata = {23'd0, plot_height_reg};
            REG_STEP:        prdata = {20'd0, step_reg};
            REG_GAIN:        prdata = {22'd0, gain_reg};
            REG_BASELINE:    prdata = {22'd0, baseline_reg};
            REG_COLORS:      prdata = colors_reg;
            default:         prdata = 32'd0;
        endcase
    end

    // derived geometry
    logic [9:0]  right, bottom;
    logic [16:0] right100;
    logic [15:0] left100;
    logic [15:0] trace_color, bg_color;

    assign right       = {1'b0, plot_left_reg} + {1'b0, plot_width_reg};
    assign bottom      = {1'b0, plot_top_reg} + {1'b0, plot_height_reg};
    assign right100    = {7'd0, right} * 17'(XSCALE);
    assign left100     = {7'd0, plot_left_reg} * 16'(XSCALE);
    assign trace_color = colors_reg[15:0];
    assign bg_color    = colors_reg[31:16];

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg;
    logic has_line_reg, has_rect_reg;
    logic in_acc, go2, go3, fire3, ready3;

    assign ready3   = !has_rect_reg || (m_tready && !has_line_reg);
    assign fire3    = v3_reg && ready3;
    assign go3      = v2_reg && (!v3_reg || fire3);
    assign go2      = v1_reg && (!v2_reg || go3);
    assign s_tready = !v1_reg || go2;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (in_acc)   v1_reg <= 1'b1;
            else if (go2) v1_reg <= 1'b0;
            if (go2)      v2_reg <= 1'b1;
            else if (go3) v2_reg <= 1'b0;
            if (go3)        v3_reg <= 1'b1;
            else if (fire3) v3_reg <= 1'b0;
        end
    end

    // input register
    logic               r1_op_reg;
    logic signed [15:0] r1_sample_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            r1_op_reg     <= s_tuser;
            r1_sample_reg <= $signed(s_tdata);
        end
    end

    // stage 1: gain product and pen x advance
    logic [14:0]        pen_x_reg;
    logic signed [26:0] prod1;
    logic [15:0]        nx, nx_sel;
    logic [16:0]        b_sum;
    logic [11:0]        adv;
    logic               wrap;

    assign prod1  = r1_sample_reg * $signed({1'b0, gain_reg});
    assign nx     = {1'b0, pen_x_reg} + {4'd0, step_reg};
    assign wrap   = {1'b0, nx} >= right100;
    assign nx_sel = wrap ? left100 : nx;
    assign adv    = (step_reg >= 12'(XSCALE)) ? step_reg : 12'(XSCALE);
    assign b_sum  = {1'b0, nx_sel} + {5'd0, adv};

    logic               r2_op_reg, r2_line_reg, r2_erase_reg;
    logic signed [26:0] r2_prod_reg;
    logic [14:0]        r2_px_reg;
    logic [15:0]        r2_nx_reg, r2_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= 15'd0;
        end else if (go2) begin
            pen_x_reg <= (r1_op_reg == OP_START) ? left100[14:0] : nx_sel[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (go2) begin
            r2_op_reg    <= r1_op_reg;
            r2_prod_reg  <= prod1;
            r2_px_reg    <= pen_x_reg;
            r2_nx_reg    <= nx_sel;
            r2_b_reg     <= b_sum[15:0];
            r2_line_reg  <= (r1_op_reg == OP_SAMPLE) && !wrap;
            r2_erase_reg <= b_sum < right100;
        end
    end

    // stage 2: divide by 100 with reciprocal multiplies
    logic [26:0] mag_full;
    logic [51:0] q_gain_prod;
    logic [33:0] q_px_prod, q_nx_prod, q_b_prod;
    logic        neg2;

    assign neg2        = r2_prod_reg[26];
    assign mag_full    = neg2 ? 27'(-r2_prod_reg) : 27'(r2_prod_reg);
    assign q_gain_prod = {26'd0, mag_full[25:0]} * {26'd0, RECIP_GAIN};
    assign q_px_prod   = {19'd0, r2_px_reg} * {16'd0, RECIP_X};
    assign q_nx_prod   = {18'd0, r2_nx_reg} * {16'd0, RECIP_X};
    assign q_b_prod    = {18'd0, r2_b_reg} * {16'd0, RECIP_X};

    logic        r3_op_reg, r3_line_reg, r3_erase_reg, r3_neg_reg;
    logic [19:0] r3_qmag_reg;
    logic [9:0]  r3_pxq_reg, r3_nxq_reg, r3_bq_reg;

    always_ff @(posedge aclk) begin
        if (go3) begin
            r3_op_reg    <= r2_op_reg;
            r3_line_reg  <= r2_line_reg;
            r3_erase_reg <= r2_erase_reg;
            r3_neg_reg   <= neg2;
            r3_qmag_reg  <= q_gain_prod[51:32];
            r3_pxq_reg   <= q_px_prod[33:24];
            r3_nxq_reg   <= q_nx_prod[33:24];
            r3_bq_reg    <= q_b_prod[33:24];
        end
    end

    // stage 3: row clamp and command build
    logic [8:0]         pen_y_reg;
    logic signed [20:0] q_s;
    logic signed [22:0] y_raw, y_clamped;
    logic [9:0]         nxq_inc;
    cmd_t               line_cmd, rect_cmd;
    cmd_t               line_cmd_reg, rect_cmd_reg;

    always_comb begin
        if (r3_op_reg == OP_START) begin
            q_s = 21'sd0;
        end else if (r3_neg_reg) begin
            q_s = -$signed({1'b0, r3_qmag_reg});
        end else begin
            q_s = $signed({1'b0, r3_qmag_reg});
        end
        y_raw = $signed({13'd0, bottom}) - 23'(q_s)
              - 23'($signed(baseline_reg));
        if (y_raw < $signed({14'd0, plot_top_reg})) begin
            y_clamped = $signed({14'd0, plot_top_reg});
        end else if (y_raw > $signed({13'd0, bottom})) begin
            y_clamped = $signed({13'd0, bottom});
        end else begin
            y_clamped = y_raw;
        end
    end

    assign nxq_inc = r3_nxq_reg + 10'd1;

    always_comb begin
        line_cmd.kind    = KIND_LINE;
        line_cmd.x_start = r3_pxq_reg[8:0];
        line_cmd.y_start = pen_y_reg;
        line_cmd.x_end   = r3_nxq_reg[8:0];
        line_cmd.y_end   = y_clamped[8:0];
        line_cmd.color   = trace_color;
        line_cmd.last    = 1'b0;

        rect_cmd.kind    = KIND_RECT;
        rect_cmd.y_start = plot_top_reg;
        rect_cmd.y_end   = bottom[8:0];
        rect_cmd.color   = bg_color;
        rect_cmd.last    = 1'b1;
        if (r3_op_reg == OP_START) begin
            rect_cmd.x_start = plot_left_reg;
            rect_cmd.x_end   = right[8:0];
        end else if (r3_erase_reg) begin
            rect_cmd.x_start = nxq_inc[8:0];
            rect_cmd.x_end   = r3_bq_reg[8:0];
        end else begin
            rect_cmd.x_start = plot_left_reg;
            rect_cmd.x_end   = plot_left_reg;
        end
    end

    // two-entry command buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_line_reg <= 1'b0;
            has_rect_reg <= 1'b0;
            pen_y_reg    <= 9'd0;
        end else if (fire3) begin
            has_line_reg <= r3_line_reg;
            has_rect_reg <= 1'b1;
            pen_y_reg    <= y_clamped[8:0];
        end else if (m_tvalid && m_tready) begin
            if (has_line_reg) begin
                has_line_reg <= 1'b0;
            end else begin
                has_rect_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire3) begin
            line_cmd_reg <= line_cmd;
            rect_cmd_reg <= rect_cmd;
        end
    end

    cmd_t out_cmd;

    assign out_cmd  = has_line_reg ? line_cmd_reg : rect_cmd_reg;
    assign m_tvalid = has_rect_reg;
    assign m_tuser  = out_cmd.kind;
    assign m_tlast  = out_cmd.last;
    assign m_tdata  = {4'd0, out_cmd.color, out_cmd.y_end, out_cmd.x_end,
                       out_cmd.y_start, out_cmd.x_start};

    // checks
    logic line_out, rect_out;

    assign line_out = m_tvalid && (m_tuser == KIND_LINE);
    assign rect_out = m_tvalid && (m_tuser == KIND_RECT);

    `ASSERT_IMPLIES(a_line_not_last, aclk, aresetn, line_out, !m_tlast)
    `ASSERT_NEXT(a_rect_after_line, aclk, aresetn, line_out && m_tready, rect_out)
    `ASSERT_IMPLIES(a_line_needs_rect, aclk, aresetn, has_line_reg, has_rect_reg)
    `ASSERT_NEXT(a_stage3_holds, aclk, aresetn, v3_reg && !ready3, v3_reg)

endmodule

`default_nettype wire
